// File: rtl/core/assert_macros.svh
// Assertion macros used by the LED blink controller RTL (lbmc_core).
// Each macro expects clk and arst_n to exist in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LBMC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbmc: implication check failed");

// Next-cycle implication, disabled during reset.
`define LBMC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbmc: next-cycle check failed");

// Invariant that holds at every clock edge outside reset.
`define LBMC_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("lbmc: invariant check failed");

`endif

// File: rtl/core/lbmc_pkg.sv
// Types and constants for the LED blink mode controller.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps

package lbmc_pkg;

	localparam int LEVELS_W = 7;

	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_SET     = 2'd1,
		REQ_OVR_ON  = 2'd2,
		REQ_OVR_OFF = 2'd3
	} req_e;

	localparam logic [2:0] MODE_OFF    = 3'd0;
	localparam logic [2:0] MODE_SLOW   = 3'd1;
	localparam logic [2:0] MODE_NORMAL = 3'd2;
	localparam logic [2:0] MODE_FAST   = 3'd3;
	localparam logic [2:0] MODE_ON     = 3'd4;

	localparam logic [31:0] NO_TIMEOUT = 32'hFFFF_FFFF;
	localparam logic [25:0] OVR_MAX    = 26'h3FF_FFFF;

	// input word
	typedef struct packed {
		req_e        req_type;
		logic [2:0]  led_index;
		logic [2:0]  mode;
		logic [31:0] timeout_ms;
	} cmd_t;

	// result word
	typedef struct packed {
		logic [LEVELS_W-1:0] led_levels;
		logic                override_active;
		logic                rejected;
	} status_t;

	// command with its timeout already converted to ticks
	typedef struct packed {
		req_e        req_type;
		logic [2:0]  led_index;
		logic [2:0]  mode;
		logic        no_timeout;
		logic [31:0] ticks;
		logic [25:0] ovr_ticks;
	} conv_cmd_t;

endpackage

// File: rtl/core/lbmc_tick_conv.sv
// Converts the millisecond timeout of each command word to ticks (divide by TICK_MS).
// Three-stage pipeline: input reg, reciprocal multiply, correction. Uses lbmc_pkg.
`timescale 1ns / 1ps

module lbmc_tick_conv #(
	parameter int TICK_MS = 125
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  lbmc_pkg::cmd_t      cmd,
	output logic                conv_valid,
	input  logic                conv_ready,
	output lbmc_pkg::conv_cmd_t conv
);

	localparam int DW = $clog2(TICK_MS + 1);
	localparam int RW = 32 + DW;
	// floor((2^32-1)/D): quotient estimate is low by at most two
	localparam logic [31:0] RECIP  = 32'(64'hFFFF_FFFF / TICK_MS);
	localparam logic [RW-1:0] DIV1 = RW'(TICK_MS);
	localparam logic [RW-1:0] DIV2 = RW'(2 * TICK_MS);

	logic           valid_s1, valid_s2, valid_s3;
	logic           ready_s1, ready_s2, ready_s3;
	lbmc_pkg::cmd_t item_s1, item_s2;
	logic [31:0]    q0_s2;
	logic [63:0]    prod;
	logic [RW-1:0]  qd, rem;
	logic [31:0]    quot;
	lbmc_pkg::conv_cmd_t conv_n;

	assign ready_s3  = !valid_s3 || conv_ready;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign cmd_ready = ready_s1;

	assign prod = 64'(item_s1.timeout_ms) * 64'(RECIP);

	always_comb begin
		qd  = RW'(q0_s2) * DIV1;
		rem = RW'(item_s2.timeout_ms) - qd;
		if (rem >= DIV2) begin
			quot = q0_s2 + 32'd2;
		end else if (rem >= DIV1) begin
			quot = q0_s2 + 32'd1;
		end else begin
			quot = q0_s2;
		end
		conv_n.req_type   = item_s2.req_type;
		conv_n.led_index  = item_s2.led_index;
		conv_n.mode       = item_s2.mode;
		conv_n.no_timeout = (item_s2.timeout_ms == lbmc_pkg::NO_TIMEOUT);
		conv_n.ticks      = quot;
		conv_n.ovr_ticks  = (quot > 32'(lbmc_pkg::OVR_MAX)) ? lbmc_pkg::OVR_MAX : quot[25:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= cmd_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && cmd_valid) item_s1 <= cmd;
		if (ready_s2 && valid_s1) begin
			item_s2 <= item_s1;
			q0_s2   <= prod[63:32];
		end
		if (ready_s3 && valid_s2) conv <= conv_n;
	end

	assign conv_valid = valid_s3;

endmodule

// File: rtl/core/lbmc_core.sv
// LED state: modes, levels, timeouts, saved copy, override and tick phase.
// One command per cycle unless status is held; holds the status word. Uses lbmc_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lbmc_core #(
	parameter int NUM_LEDS = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                conv_valid,
	output logic                conv_ready,
	input  lbmc_pkg::conv_cmd_t conv,
	output logic                status_valid,
	input  logic                status_ready,
	output lbmc_pkg::status_t   status
);

	localparam int NV = (NUM_LEDS < lbmc_pkg::LEVELS_W) ? NUM_LEDS : lbmc_pkg::LEVELS_W;

	logic [2:0]  mode_q   [NUM_LEDS];
	logic        level_q  [NUM_LEDS];
	logic [31:0] ticks_q  [NUM_LEDS];
	logic [2:0]  smode_q  [NUM_LEDS];
	logic        slevel_q [NUM_LEDS];
	logic [31:0] sticks_q [NUM_LEDS];
	logic        on_q;
	logic [25:0] oticks_q;
	logic [2:0]  phase_q;

	logic [2:0]  mode_n   [NUM_LEDS];
	logic        level_n  [NUM_LEDS];
	logic [31:0] ticks_n  [NUM_LEDS];
	logic [2:0]  smode_n  [NUM_LEDS];
	logic        slevel_n [NUM_LEDS];
	logic [31:0] sticks_n [NUM_LEDS];
	logic        on_n;
	logic [25:0] oticks_n;
	logic [2:0]  phase_n;
	logic        rej_n;
	logic        restore;
	logic        acc;
	logic [lbmc_pkg::LEVELS_W-1:0] levels_n, levels_cur;
	logic        status_valid_q;
	lbmc_pkg::status_t status_q;

	assign conv_ready = !status_valid_q || status_ready;
	assign acc        = conv_valid && conv_ready;

	always_comb begin
		mode_n   = mode_q;
		level_n  = level_q;
		ticks_n  = ticks_q;
		smode_n  = smode_q;
		slevel_n = slevel_q;
		sticks_n = sticks_q;
		on_n     = on_q;
		oticks_n = oticks_q;
		phase_n  = phase_q;
		rej_n    = 1'b0;
		restore  = 1'b0;
		if (acc) begin
			case (conv.req_type)
				lbmc_pkg::REQ_TICK: begin
					for (int i = 0; i < NUM_LEDS; i++) begin
						case (mode_q[i])
							lbmc_pkg::MODE_OFF:    level_n[i] = 1'b1;
							lbmc_pkg::MODE_SLOW:   if (phase_q == 3'd0) level_n[i] = !level_q[i];
							lbmc_pkg::MODE_NORMAL: if (phase_q[1:0] == 2'd0) level_n[i] = !level_q[i];
							lbmc_pkg::MODE_FAST:   level_n[i] = !level_q[i];
							lbmc_pkg::MODE_ON:     level_n[i] = 1'b0;
							default:               level_n[i] = level_q[i];
						endcase
						if (ticks_q[i] != lbmc_pkg::NO_TIMEOUT) begin
							ticks_n[i] = ticks_q[i] - 32'd1;
							// wrap from zero: timeout expired
							if (ticks_q[i] == 32'd0) mode_n[i] = lbmc_pkg::MODE_OFF;
						end
					end
					if (oticks_q != 26'd0) begin
						oticks_n = oticks_q - 26'd1;
						if (oticks_q == 26'd1 && on_q) restore = 1'b1;
					end
					phase_n = phase_q + 3'd1;
				end
				lbmc_pkg::REQ_SET: begin
					if (int'(conv.led_index) >= NUM_LEDS) begin
						rej_n = 1'b1;
					end else begin
						for (int i = 0; i < NUM_LEDS; i++) begin
							if (int'(conv.led_index) == i) begin
								if (on_q) begin
									smode_n[i] = conv.mode;
									if (!conv.no_timeout) sticks_n[i] = conv.ticks;
								end else begin
									mode_n[i] = conv.mode;
									if (!conv.no_timeout) ticks_n[i] = conv.ticks;
								end
							end
						end
					end
				end
				lbmc_pkg::REQ_OVR_ON: begin
					oticks_n = conv.no_timeout ? 26'd0 : conv.ovr_ticks;
					if (!on_q) begin
						smode_n  = mode_q;
						slevel_n = level_q;
						sticks_n = ticks_q;
					end
					for (int i = 0; i < NUM_LEDS; i++) begin
						level_n[i] = 1'b0;
						mode_n[i]  = conv.mode;
						if (!conv.no_timeout) ticks_n[i] = conv.ticks;
					end
					on_n = 1'b1;
				end
				lbmc_pkg::REQ_OVR_OFF: begin
					if (on_q) restore = 1'b1;
				end
				default: begin
				end
			endcase
		end
		if (restore) begin
			mode_n   = smode_q;
			level_n  = slevel_q;
			ticks_n  = sticks_q;
			on_n     = 1'b0;
			oticks_n = 26'd0;
		end
	end

	always_comb begin
		levels_n   = '0;
		levels_cur = '0;
		for (int i = 0; i < NV; i++) begin
			levels_n[i]   = level_n[i];
			levels_cur[i] = level_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				mode_q[i]   <= (i == 0) ? lbmc_pkg::MODE_NORMAL : lbmc_pkg::MODE_OFF;
				level_q[i]  <= 1'b0;
				ticks_q[i]  <= lbmc_pkg::NO_TIMEOUT;
				smode_q[i]  <= 3'd0;
				slevel_q[i] <= 1'b0;
				sticks_q[i] <= 32'd0;
			end
			on_q           <= 1'b0;
			oticks_q       <= 26'd0;
			phase_q        <= 3'd0;
			status_valid_q <= 1'b0;
		end else begin
			mode_q   <= mode_n;
			level_q  <= level_n;
			ticks_q  <= ticks_n;
			smode_q  <= smode_n;
			slevel_q <= slevel_n;
			sticks_q <= sticks_n;
			on_q     <= on_n;
			oticks_q <= oticks_n;
			phase_q  <= phase_n;
			if (conv_ready) status_valid_q <= conv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q.led_levels      <= levels_n;
			status_q.override_active <= on_n;
			status_q.rejected        <= rej_n;
		end
	end

	assign status_valid = status_valid_q;
	assign status       = status_q;

	`LBMC_ASSERT_ALWAYS(a_ovr_cnt_idle, on_q || (oticks_q == 26'd0))
	`LBMC_ASSERT_IMP(a_status_ovr, status_valid_q, status_q.override_active == on_q)
	`LBMC_ASSERT_IMP(a_status_lvl, status_valid_q, status_q.led_levels == levels_cur)
	`LBMC_ASSERT_NEXT(a_phase_step, acc && (conv.req_type == lbmc_pkg::REQ_TICK),
		phase_q == 3'($past(phase_q) + 3'd1))

endmodule

// File: rtl/core/led_blink_mode_controller.sv
// LED blink mode controller: one status word per command word, in order.
// Registered path: input reg, multiply, correction, then the status register in lbmc_core.
// Throughput: one command per cycle; a held status word stalls only once the pipe is full.
// Reset (arst_n low, async): LED0 normal, others off, no timeouts, override off, phase 0.
// Depends on lbmc_pkg, lbmc_tick_conv, lbmc_core.
`timescale 1ns / 1ps

module led_blink_mode_controller #(
	parameter int NUM_LEDS = 7,
	parameter int TICK_MS  = 125
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  lbmc_pkg::cmd_t    cmd,
	output logic              status_valid,
	input  logic              status_ready,
	output lbmc_pkg::status_t status
);

	logic                conv_valid;
	logic                conv_ready;
	lbmc_pkg::conv_cmd_t conv;

	lbmc_tick_conv #(
		.TICK_MS(TICK_MS)
	) u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.conv_valid(conv_valid),
		.conv_ready(conv_ready),
		.conv      (conv)
	);

	lbmc_core #(
		.NUM_LEDS(NUM_LEDS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.conv_valid  (conv_valid),
		.conv_ready  (conv_ready),
		.conv        (conv),
		.status_valid(status_valid),
		.status_ready(status_ready),
		.status      (status)
	);

endmodule

// File: dv/lbmc_status_checker.sv
// Status checker for the LED blink mode controller: watches both channels, predicts each
// status word from the accepted command words and compares them in order.
// Depends on lbmc_pkg.
`timescale 1ns / 1ps

module lbmc_status_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic              cmd_ready,
	input  lbmc_pkg::cmd_t    cmd,
	input  logic              status_valid,
	input  logic              status_ready,
	input  lbmc_pkg::status_t status,
	output int                errors,
	output int                pending
);

	localparam int LEDS    = 7;
	localparam int TICK_MS = 125;

	// predicted controller state
	logic [2:0]  md       [LEDS];
	logic        lvl      [LEDS];
	logic [31:0] tleft    [LEDS];
	logic [2:0]  sv_md    [LEDS];
	logic        sv_lvl   [LEDS];
	logic [31:0] sv_tleft [LEDS];
	logic        ovr_on;
	logic [25:0] ovr_left;
	logic [2:0]  phase;

	lbmc_pkg::status_t expected_status_q[$];

	function automatic void restore_saved_leds();
		for (int i = 0; i < LEDS; i++) begin
			md[i]    = sv_md[i];
			lvl[i]   = sv_lvl[i];
			tleft[i] = sv_tleft[i];
		end
		ovr_on   = 1'b0;
		ovr_left = '0;
	endfunction

	function automatic lbmc_pkg::status_t advance_leds(input lbmc_pkg::cmd_t c);
		lbmc_pkg::status_t s;
		logic [31:0]       ticks;
		ticks = c.timeout_ms / TICK_MS;
		s     = '0;
		case (c.req_type)
			lbmc_pkg::REQ_TICK: begin
				for (int i = 0; i < LEDS; i++) begin
					case (md[i])
						lbmc_pkg::MODE_OFF:    lvl[i] = 1'b1;
						lbmc_pkg::MODE_SLOW:   if (phase == 3'd0) lvl[i] = ~lvl[i];
						lbmc_pkg::MODE_NORMAL: if (phase[1:0] == 2'd0) lvl[i] = ~lvl[i];
						lbmc_pkg::MODE_FAST:   lvl[i] = ~lvl[i];
						lbmc_pkg::MODE_ON:     lvl[i] = 1'b0;
						default:               ;
					endcase
					// countdown wraps past zero: LED switches off
					if (tleft[i] != lbmc_pkg::NO_TIMEOUT) begin
						tleft[i] = tleft[i] - 32'd1;
						if (tleft[i] == lbmc_pkg::NO_TIMEOUT)
							md[i] = lbmc_pkg::MODE_OFF;
					end
				end
				if (ovr_left != '0) begin
					ovr_left = ovr_left - 26'd1;
					if (ovr_left == '0 && ovr_on)
						restore_saved_leds();
				end
				phase = phase + 3'd1;
			end
			lbmc_pkg::REQ_SET: begin
				if (int'(c.led_index) >= LEDS) begin
					s.rejected = 1'b1;
				end else if (ovr_on) begin
					sv_md[c.led_index] = c.mode;
					if (c.timeout_ms != lbmc_pkg::NO_TIMEOUT) sv_tleft[c.led_index] = ticks;
				end else begin
					md[c.led_index] = c.mode;
					if (c.timeout_ms != lbmc_pkg::NO_TIMEOUT) tleft[c.led_index] = ticks;
				end
			end
			lbmc_pkg::REQ_OVR_ON: begin
				if (c.timeout_ms == lbmc_pkg::NO_TIMEOUT)
					ovr_left = '0;
				else
					ovr_left = (ticks > 32'(lbmc_pkg::OVR_MAX)) ? lbmc_pkg::OVR_MAX
						: ticks[25:0];
				// a second enable keeps the first saved copy
				if (!ovr_on) begin
					for (int i = 0; i < LEDS; i++) begin
						sv_md[i]    = md[i];
						sv_lvl[i]   = lvl[i];
						sv_tleft[i] = tleft[i];
					end
				end
				for (int i = 0; i < LEDS; i++) begin
					lvl[i] = 1'b0;
					md[i]  = c.mode;
					if (c.timeout_ms != lbmc_pkg::NO_TIMEOUT) tleft[i] = ticks;
				end
				ovr_on = 1'b1;
			end
			lbmc_pkg::REQ_OVR_OFF: begin
				if (ovr_on)
					restore_saved_leds();
			end
			default: ;
		endcase
		for (int i = 0; i < LEDS; i++)
			s.led_levels[i] = lvl[i];
		s.override_active = ovr_on;
		return s;
	endfunction

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: status %s mismatch: expected %0h, actual %0h",
				$time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		lbmc_pkg::status_t exp_s;
		if (!arst_n) begin
			for (int i = 0; i < LEDS; i++) begin
				md[i]       = (i == 0) ? lbmc_pkg::MODE_NORMAL : lbmc_pkg::MODE_OFF;
				lvl[i]      = 1'b0;
				tleft[i]    = lbmc_pkg::NO_TIMEOUT;
				sv_md[i]    = lbmc_pkg::MODE_OFF;
				sv_lvl[i]   = 1'b0;
				sv_tleft[i] = '0;
			end
			ovr_on   = 1'b0;
			ovr_left = '0;
			phase    = '0;
			errors   = 0;
			expected_status_q.delete();
		end else begin
			if (cmd_valid && cmd_ready)
				expected_status_q.push_back(advance_leds(cmd));
			if (status_valid && status_ready) begin
				if (expected_status_q.size() == 0) begin
					$display("%0t: status word with none expected: expected nothing, actual %p",
						$time, status);
					errors++;
				end else begin
					exp_s = expected_status_q.pop_front();
					check_field("led_levels", int'(exp_s.led_levels),
						int'(status.led_levels));
					check_field("override_active", int'(exp_s.override_active),
						int'(status.override_active));
					check_field("rejected", int'(exp_s.rejected), int'(status.rejected));
				end
			end
		end
		pending = expected_status_q.size();
	end

endmodule

// File: dv/tb_led_blink_mode_controller.sv
// Testbench top for the LED blink mode controller: clock, reset, command and status
// traffic, watchdog and verdict. Depends on lbmc_pkg, lbmc_status_checker and the block.
`timescale 1ns / 1ps

module tb_led_blink_mode_controller;

	localparam int RANDOM_WORDS = 1950;
	localparam int HOLD_START   = 400;
	localparam int HOLD_CYCLES  = 300;
	localparam int CALM_FIRST   = 1200;
	localparam int CALM_LAST    = 1500;
	localparam int IDLE_PCT     = 16;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 20;

	logic              clk;
	logic              arst_n;
	logic              cmd_valid;
	logic              cmd_ready;
	lbmc_pkg::cmd_t    cmd;
	logic              status_valid;
	logic              status_ready;
	lbmc_pkg::status_t status;
	int                errors;
	int                pending;

	int      words_sent;
	int      stall_cycles;
	bit      held_off;

	led_blink_mode_controller DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.status_valid (status_valid),
		.status_ready (status_ready),
		.status       (status)
	);

	lbmc_status_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.status_valid (status_valid),
		.status_ready (status_ready),
		.status       (status),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit calm_stretch();
		return words_sent >= CALM_FIRST && words_sent < CALM_LAST;
	endfunction

	function automatic lbmc_pkg::cmd_t mk_cmd(input lbmc_pkg::req_e r, input logic [2:0] idx,
		input logic [2:0] m, input logic [31:0] t);
		lbmc_pkg::cmd_t c;
		c.req_type   = r;
		c.led_index  = idx;
		c.mode       = m;
		c.timeout_ms = t;
		return c;
	endfunction

	// mostly short timeouts so LED and override expiry are reached often
	function automatic logic [31:0] pick_timeout();
		case ($urandom_range(0, 9))
			6:       return lbmc_pkg::NO_TIMEOUT;
			7:       return $urandom();
			8:       return $urandom_range(0, 1) ? lbmc_pkg::NO_TIMEOUT - 32'd1 : 32'd125;
			9:       return $urandom_range(0, 124);
			default: return $urandom_range(0, 3000);
		endcase
	endfunction

	function automatic logic [2:0] pick_mode();
		if ($urandom_range(0, 9) < 8)
			return 3'($urandom_range(lbmc_pkg::MODE_OFF, lbmc_pkg::MODE_ON));
		return 3'($urandom_range(5, 7));
	endfunction

	function automatic logic [2:0] rnd3();
		return 3'($urandom_range(0, 7));
	endfunction

	function automatic lbmc_pkg::cmd_t random_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return mk_cmd(lbmc_pkg::REQ_TICK, rnd3(), rnd3(), $urandom());
		if (r < 80)
			return mk_cmd(lbmc_pkg::REQ_SET, rnd3(), pick_mode(), pick_timeout());
		if (r < 90)
			return mk_cmd(lbmc_pkg::REQ_OVR_ON, rnd3(), pick_mode(), pick_timeout());
		return mk_cmd(lbmc_pkg::REQ_OVR_OFF, rnd3(), rnd3(), $urandom());
	endfunction

	task automatic send_cmd(input lbmc_pkg::cmd_t c);
		while (!calm_stretch() && $urandom_range(0, 99) < IDLE_PCT) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		words_sent++;
	endtask

	// receiver: random back-pressure, one long hold-off while the sender keeps going
	initial begin
		status_ready <= 1'b0;
		held_off = 1'b0;
		forever begin
			@(posedge clk);
			if (!held_off && words_sent >= HOLD_START) begin
				held_off = 1'b1;
				status_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				status_ready <= calm_stretch() || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (status_valid && status_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("tb_led_blink_mode_controller: FAIL");
			$finish;
		end
	end

	initial begin
		words_sent   = 0;
		arst_n      <= 1'b0;
		cmd_valid   <= 1'b0;
		cmd         <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: modes, reserved modes, index out of range, timeout edges, override paths
		send_cmd(mk_cmd(lbmc_pkg::REQ_TICK, 3'd0, lbmc_pkg::MODE_OFF, 32'd0));
		send_cmd(mk_cmd(lbmc_pkg::REQ_SET, 3'd0, lbmc_pkg::MODE_FAST, lbmc_pkg::NO_TIMEOUT));
		send_cmd(mk_cmd(lbmc_pkg::REQ_SET, 3'd6, lbmc_pkg::MODE_ON, 32'd0));
		send_cmd(mk_cmd(lbmc_pkg::REQ_SET, 3'd7, lbmc_pkg::MODE_SLOW, 32'd500));
		send_cmd(mk_cmd(lbmc_pkg::REQ_SET, 3'd1, lbmc_pkg::MODE_SLOW, 32'd124));
		send_cmd(mk_cmd(lbmc_pkg::REQ_SET, 3'd2, 3'd7, 32'd250));
		send_cmd(mk_cmd(lbmc_pkg::REQ_SET, 3'd3, lbmc_pkg::MODE_OFF,
			lbmc_pkg::NO_TIMEOUT - 32'd1));
		send_cmd(mk_cmd(lbmc_pkg::REQ_TICK, 3'd7, 3'd7, lbmc_pkg::NO_TIMEOUT));
		send_cmd(mk_cmd(lbmc_pkg::REQ_TICK, 3'd0, lbmc_pkg::MODE_OFF, 32'd0));
		send_cmd(mk_cmd(lbmc_pkg::REQ_OVR_OFF, 3'd0, lbmc_pkg::MODE_OFF, 32'd0));
		send_cmd(mk_cmd(lbmc_pkg::REQ_OVR_ON, 3'd0, lbmc_pkg::MODE_FAST, 32'd250));
		send_cmd(mk_cmd(lbmc_pkg::REQ_SET, 3'd4, lbmc_pkg::MODE_NORMAL, 32'd1000));
		send_cmd(mk_cmd(lbmc_pkg::REQ_OVR_ON, 3'd0, lbmc_pkg::MODE_ON, lbmc_pkg::NO_TIMEOUT));
		send_cmd(mk_cmd(lbmc_pkg::REQ_TICK, 3'd0, lbmc_pkg::MODE_OFF, 32'd0));
		send_cmd(mk_cmd(lbmc_pkg::REQ_OVR_OFF, 3'd7, 3'd7, lbmc_pkg::NO_TIMEOUT));
		send_cmd(mk_cmd(lbmc_pkg::REQ_OVR_ON, 3'd0, lbmc_pkg::MODE_SLOW, 32'd375));
		repeat (3) send_cmd(mk_cmd(lbmc_pkg::REQ_TICK, 3'd0, lbmc_pkg::MODE_OFF, 32'd0));
		send_cmd(mk_cmd(lbmc_pkg::REQ_SET, 3'd5, 3'd5, 32'd0));
		send_cmd(mk_cmd(lbmc_pkg::REQ_TICK, 3'd0, lbmc_pkg::MODE_OFF, 32'd0));
		send_cmd(mk_cmd(lbmc_pkg::REQ_OVR_ON, 3'd0, 3'd6, lbmc_pkg::NO_TIMEOUT - 32'd1));
		send_cmd(mk_cmd(lbmc_pkg::REQ_TICK, 3'd0, lbmc_pkg::MODE_OFF, 32'd0));
		send_cmd(mk_cmd(lbmc_pkg::REQ_OVR_OFF, 3'd0, lbmc_pkg::MODE_OFF, 32'd0));

		repeat (RANDOM_WORDS) send_cmd(random_cmd());
		cmd_valid <= 1'b0;

		// let the checker take the last word before looking at the count
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_led_blink_mode_controller: PASS");
		else
			$display("tb_led_blink_mode_controller: FAIL");
		$finish;
	end

endmodule
